/* sv/nta_pkg.sv */
// nta_pkg.sv: shared types, codes and helper functions of the number-to-ASCII formatter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package nta_pkg;

   // Format commands on the request channel
   localparam logic [1:0] CMD_DEC       = 2'd0;
   localparam logic [1:0] CMD_HEX_LOWER = 2'd1;
   localparam logic [1:0] CMD_HEX_UPPER = 2'd2;

   // Job modes, settled by the front end
   localparam logic [1:0] MODE_DEC    = 2'd0;
   localparam logic [1:0] MODE_HEX_LO = 2'd1;
   localparam logic [1:0] MODE_HEX_UP = 2'd2;
   localparam logic [1:0] MODE_ERR    = 2'd3;

   localparam logic [3:0] HEX_MAX_NIBBLES = 4'd8;
   localparam logic [6:0] ASCII_ZERO      = 7'h30;
   localparam logic [6:0] ASCII_LO_A      = 7'h61;
   localparam logic [6:0] ASCII_UP_A      = 7'h41;

   // Digit weights for the decimal sequencer
   localparam logic [31:0] POW10_TAB [0:7] = '{
      32'd1, 32'd10, 32'd100, 32'd1000,
      32'd10000, 32'd100000, 32'd1000000, 32'd10000000
   };

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] value;
      logic [3:0]  hex_width;
   } req_type;

   typedef struct packed {
      logic [6:0] character;
      logic       last;
      logic       error;
   } rsp_type;

   // One classified number waiting for the back end
   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] value;
      logic [3:0]  count;
   } job_type;

   function automatic logic [31:0] pow10(input int unsigned n);
      logic [31:0] p;
      p = 32'd1;
      for (int unsigned i = 0; i < n; i++) begin
         p = p * 32'd10;
      end
      return p;
   endfunction

   function automatic logic [6:0] nibble_char(input logic [3:0] nib, input logic upper);
      logic [6:0] c;
      if (nib < 4'd10) begin
         c = ASCII_ZERO + 7'(nib);
      end else begin
         c = (upper ? ASCII_UP_A : ASCII_LO_A) + 7'(nib - 4'd10);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* sv/nta_front.sv */
// nta_front.sv: accepts requests and classifies them into jobs (mode, character count).
// Depends on nta_pkg.
`default_nettype none

module nta_front #(
   parameter int unsigned MAX_DIGITS = 8
) (
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire nta_pkg::req_type req_data,
   input  wire logic             queue_full,
   output logic                  push,
   output nta_pkg::job_type      job
);
   import nta_pkg::*;

   localparam logic [31:0] DEC_LIMIT = pow10(MAX_DIGITS);

   logic [3:0] dec_count;
   logic [3:0] hex_count;
   logic       too_long;

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;
   assign too_long  = req_data.value >= DEC_LIMIT;

   // Count decimal digits: one plus the number of weights the value reaches
   always_comb begin
      dec_count = 4'd1;
      for (int unsigned k = 1; k < MAX_DIGITS; k++) begin
         if (req_data.value >= pow10(k)) begin
            dec_count = dec_count + 4'd1;
         end
      end
   end

   always_comb begin
      if (req_data.hex_width == 4'd0 || req_data.hex_width > HEX_MAX_NIBBLES) begin
         hex_count = HEX_MAX_NIBBLES;
      end else begin
         hex_count = req_data.hex_width;
      end
   end

   always_comb begin
      job.value = req_data.value;
      unique case (req_data.command)
         CMD_DEC: begin
            job.mode  = too_long ? MODE_ERR : MODE_DEC;
            job.count = too_long ? 4'd1 : dec_count;
         end
         CMD_HEX_LOWER: begin
            job.mode  = MODE_HEX_LO;
            job.count = hex_count;
         end
         default: begin
            job.mode  = MODE_HEX_UP;
            job.count = hex_count;
         end
      endcase
   end

endmodule

`default_nettype wire

/* sv/nta_queue.sv */
// nta_queue.sv: two-entry job queue between the front end and the back end.
// Depends on nta_pkg.
`default_nettype none

module nta_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire nta_pkg::job_type push_job,
   output logic                  full,
   input  wire logic             pop,
   output logic                  head_valid,
   output nta_pkg::job_type      head_job
);
   import nta_pkg::*;

   localparam int unsigned DEPTH = 2;
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   job_type             entry_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;

   assign full       = fill_ff == CNT_W'(DEPTH);
   assign head_valid = fill_ff != '0;
   assign head_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

/* sv/nta_back.sv */
// nta_back.sv: char sequencer; one ASCII char per cycle into an output register unless stalled.
// Depends on nta_pkg.
`default_nettype none

module nta_back #(
   parameter int unsigned MAX_DIGITS = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             head_valid,
   input  wire nta_pkg::job_type head_job,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output nta_pkg::rsp_type      rsp_data
);
   import nta_pkg::*;

   // Decimal remainders stay below 10^MAX_DIGITS
   localparam int unsigned DEC_W = $clog2(pow10(MAX_DIGITS));

   logic             busy_ff, busy_in;
   logic [1:0]       mode_ff, mode_in;
   logic [31:0]      val_ff, val_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             out_free;
   logic             step;
   logic [3:0]       pos;
   logic [2:0]       idx;
   logic [3:0]       nib;
   logic [DEC_W-1:0] rem;
   logic [DEC_W-1:0] mult;
   logic [DEC_W-1:0] sub;
   logic [3:0]       digit;
   rsp_type          char_data;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step      = busy_ff && out_free;
   assign pos       = cnt_ff - 4'd1;
   assign idx       = pos[2:0];
   assign nib       = val_ff[{idx, 2'b00} +: 4];
   assign rem       = val_ff[DEC_W-1:0];
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Pick the largest multiple of the digit weight that fits the remainder
   always_comb begin
      mult  = '0;
      sub   = '0;
      digit = 4'd0;
      for (int unsigned d = 1; d <= 9; d++) begin
         mult = DEC_W'(POW10_TAB[idx] * 32'(d));
         if (rem >= mult) begin
            sub   = mult;
            digit = 4'(d);
         end
      end
   end

   always_comb begin
      char_data.last  = cnt_ff == 4'd1;
      char_data.error = 1'b0;
      unique case (mode_ff)
         MODE_DEC:    char_data.character = ASCII_ZERO + 7'(digit);
         MODE_HEX_LO: char_data.character = nibble_char(nib, 1'b0);
         MODE_HEX_UP: char_data.character = nibble_char(nib, 1'b1);
         default: begin
            char_data.character = 7'd0;
            char_data.last      = 1'b1;
            char_data.error     = 1'b1;
         end
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      mode_in      = mode_ff;
      val_in       = val_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = char_data;
         cnt_in       = cnt_ff - 4'd1;
         if (mode_ff == MODE_DEC) begin
            val_in = 32'(rem - sub);
         end
         if (cnt_ff == 4'd1) begin
            busy_in = 1'b0;
         end
      end else if (!busy_ff && head_valid) begin
         pop     = 1'b1;
         busy_in = 1'b1;
         mode_in = head_job.mode;
         val_in  = head_job.value;
         cnt_in  = head_job.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      val_ff      <= val_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_busy_has_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != 4'd0)
      else $error("sequencer busy with no characters left");

   a_last_ends_job: assert property (@(posedge clock) disable iff (reset)
      step && cnt_ff == 4'd1 |=> !busy_ff)
      else $error("sequencer still busy after the last character");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      step && mode_ff == MODE_DEC |-> digit <= 4'd9 && rem - sub < DEC_W'(POW10_TAB[idx]))
      else $error("decimal remainder not below the digit weight");

   a_no_pop_while_busy: assert property (@(posedge clock) disable iff (reset)
      pop |-> !busy_ff && head_valid)
      else $error("job taken while sequencer busy");
`endif

endmodule

`default_nettype wire

/* sv/number_to_ascii_formatter_top.sv */
// number_to_ascii_formatter_top.sv: top level of the number-to-ASCII formatter.
// Depends on nta_pkg, nta_front, nta_queue and nta_back.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------------
//   req     | in        | req_valid / req_ready  | req_data: command, value, hex_width
//   rsp     | out       | rsp_valid / rsp_ready  | rsp_data: character, last, error
//
// The back-end sequencer loads a job from the queue, then emits its characters one
// per cycle while the output register is free, and loads the next job only after
// the job's last character. A single digit or an error result is one character.
// The front end takes a new transaction whenever the two-entry queue has room, so
// requests keep flowing while the sequencer or the output register is stalled.
// Synchronous reset clears the queue, the sequencer and the output valid.
`default_nettype none

module number_to_ascii_formatter_top #(
   parameter int unsigned MAX_DIGITS = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire nta_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output nta_pkg::rsp_type      rsp_data
);
   import nta_pkg::*;

   logic    push;
   logic    queue_full;
   logic    pop;
   logic    head_valid;
   job_type push_job;
   job_type head_job;

   // Classify each transaction: hex width, decimal digit count, overflow
   nta_front #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .job        (push_job)
   );

   // Hold classified jobs so each side can stall on its own
   nta_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // Emit characters, most significant first, through the output register
   nta_back #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire
